/* hw/rtl/escape_decode_tab_expand_macros.svh */
// Assertion helpers shared by the RTL of the escape decoder.
// Every check is clocked on i_clk and is disabled while i_rst_n is low.
`ifndef ESCAPE_DECODE_TAB_EXPAND_MACROS_SVH
`define ESCAPE_DECODE_TAB_EXPAND_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDTE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("escape decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define EDTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("escape decoder check failed");

`endif

/* hw/rtl/edte_pkg.sv */
package edte_pkg;

    // Spaces emitted for one tab, capped at sixteen.
    localparam int TAB_WIDTH = 4;
    localparam int TAB_CNT   = (TAB_WIDTH > 16) ? 16 : TAB_WIDTH;
    localparam int REP_W     = (TAB_CNT > 1) ? $clog2(TAB_CNT) : 1;

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_BSLASH = 2'd1,
        PH_X      = 2'd2,
        PH_XH     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MAIN_NONE = 2'd0,
        MAIN_BYTE = 2'd1,
        MAIN_TAB  = 2'd2
    } t_main;

    // One decoded request: up to four output tokens, emitted from index 0 up.
    // When rep is set the final token is repeated TAB_CNT times.
    typedef struct packed {
        logic [3:0][7:0] tok;
        logic [2:0]      n_tok;
        logic            rep;
        logic            last;
    } t_job;

    function automatic logic hex_digit(input logic [7:0] c);
        hex_digit = (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end
        hex_nibble = v[3:0];
    endfunction

endpackage

/* hw/rtl/escape_decode_tab_expand.sv */
// Streaming decoder for C-style escaped values, with tab expansion.
// Input stream (s_axis): one raw byte per request in tdata, tlast on the final
// byte of a value. Output stream (m_axis): one decoded byte per request, tlast
// on the final decoded byte of a value. Configuration channel (i_cfg_*): one
// bit, escape enable, written whenever i_cfg_valid is high (always ready);
// write it only while the block is idle.
// Each input byte is decoded in the cycle it is accepted into a request of
// up to seven output bytes, held in the request register; its first byte then
// passes to the output register and is presented on m_axis. A request that
// yields at most one output byte leaves the input ready, so such bytes stream
// at one per cycle while the receiver keeps up; a request that yields more
// bytes emits them one at a time through the single-byte output register and
// holds the input off until its final byte. A tab expands to four spaces, a
// failed hex escape replays up to three bytes ahead of the byte that broke it.
// When the receiver stalls, the output register holds its byte, the pending
// request waits, and s_axis_tready drops until the request drains.
// Reset (i_rst_n low, synchronous) empties both stages, returns the decoder
// to the normal phase and sets escape enable to one.
module escape_decode_tab_expand (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_data,      // [0] escape_enable
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast
);

`include "escape_decode_tab_expand_macros.svh"

    logic                      r_esc_en;
    edte_pkg::t_phase          r_phase;
    logic [7:0]                r_held;
    edte_pkg::t_job            r_job;
    logic                      r_job_valid;
    logic [1:0]                r_tok_idx;
    logic [edte_pkg::REP_W-1:0] r_rep;
    logic                      r_out_valid;
    logic [7:0]                r_out_data;
    logic                      r_out_last;

    edte_pkg::t_job            w_dec_job;
    edte_pkg::t_phase          w_dec_phase;
    logic [7:0]                w_dec_held;
    logic                      w_accept;
    logic                      w_out_load;
    logic                      w_emit;
    logic                      w_last_tok;
    logic                      w_final;
    logic                      w_job_done;

    edte_dec u_dec (
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_esc_en (r_esc_en),
        .i_phase  (r_phase),
        .i_held   (r_held),
        .o_job    (w_dec_job),
        .o_phase  (w_dec_phase),
        .o_held   (w_dec_held)
    );

    // The output register loads whenever it is empty or being drained.
    assign w_out_load = !r_out_valid || m_axis_tready;
    assign w_emit     = r_job_valid && (r_job.n_tok != 3'd0) && w_out_load;
    assign w_last_tok = ({1'b0, r_tok_idx} == (r_job.n_tok - 3'd1));
    // The final byte of a request is its last token, on the last repeat.
    assign w_final    = w_last_tok &&
                        (!r_job.rep || r_rep == edte_pkg::REP_W'(edte_pkg::TAB_CNT - 1));
    assign w_job_done = r_job_valid && ((r_job.n_tok == 3'd0) || (w_emit && w_final));

    assign s_axis_tready = !r_job_valid || w_job_done;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_esc_en <= i_cfg_data[0];
        end
    end

    // Escape state advances with every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= edte_pkg::PH_NORMAL;
            r_held  <= 8'h00;
        end else if (w_accept) begin
            r_phase <= w_dec_phase;
            r_held  <= w_dec_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (w_accept) begin
            r_job_valid <= 1'b1;
        end else if (w_job_done) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= w_dec_job;
        end
    end

    // Position inside the pending request: token index and repeat count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_idx <= 2'd0;
            r_rep     <= '0;
        end else if (w_emit) begin
            if (w_final) begin
                r_tok_idx <= 2'd0;
                r_rep     <= '0;
            end else if (r_job.rep && w_last_tok) begin
                r_rep <= r_rep + edte_pkg::REP_W'(1);
            end else begin
                r_tok_idx <= r_tok_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= r_job.tok[r_tok_idx];
            r_out_last <= r_job.last && w_final;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // The emit position always points inside the pending request.
    `EDTE_ASSERT_SAME(a_idx_in_job, r_job_valid && r_job.n_tok != 3'd0,
        {1'b0, r_tok_idx} < r_job.n_tok)
    // Repeats only run on the final token of a tab request.
    `EDTE_ASSERT_SAME(a_rep_on_tab, r_rep != '0, r_job_valid && r_job.rep && w_last_tok)
    // The end of a value always returns the decoder to the normal phase and yields at least one output byte.
    `EDTE_ASSERT_NEXT(a_last_resets_phase, w_accept && s_axis_tlast,
        r_phase == edte_pkg::PH_NORMAL && r_job.n_tok != 3'd0)

endmodule

/* hw/rtl/edte_dec.sv */
// Decodes one input byte against the escape state into a token list and
// the next escape state.
module edte_dec (
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_esc_en,
    input  edte_pkg::t_phase  i_phase,
    input  logic [7:0]        i_held,
    output edte_pkg::t_job    o_job,
    output edte_pkg::t_phase  o_phase,
    output logic [7:0]        o_held
);

    edte_pkg::t_main  pl_kind;
    edte_pkg::t_phase pl_phase;
    edte_pkg::t_main  kind;
    logic [7:0]       mbyte;
    logic [1:0]       pre_cnt;
    logic [7:0]       third;
    edte_pkg::t_phase nxt_phase;
    logic [7:0]       nxt_held;

    // Handling of a byte in the normal phase.
    always_comb begin
        pl_phase = edte_pkg::PH_NORMAL;
        pl_kind  = edte_pkg::MAIN_BYTE;
        if (i_esc_en && i_byte == edte_pkg::CH_BSL) begin
            if (!i_last) begin
                pl_kind  = edte_pkg::MAIN_NONE;
                pl_phase = edte_pkg::PH_BSLASH;
            end
        end else if (i_byte == edte_pkg::CH_TAB) begin
            pl_kind = edte_pkg::MAIN_TAB;
        end
    end

    always_comb begin
        kind      = edte_pkg::MAIN_NONE;
        mbyte     = i_byte;
        pre_cnt   = 2'd0;
        third     = i_held;
        nxt_phase = edte_pkg::PH_NORMAL;
        nxt_held  = i_held;
        case (i_phase)
            edte_pkg::PH_NORMAL: begin
                kind      = pl_kind;
                nxt_phase = pl_phase;
            end
            edte_pkg::PH_BSLASH: begin
                kind = edte_pkg::MAIN_BYTE;
                case (i_byte)
                    edte_pkg::CH_N:    mbyte = edte_pkg::CH_LF;
                    edte_pkg::CH_R:    mbyte = edte_pkg::CH_CR;
                    edte_pkg::CH_ZERO: mbyte = edte_pkg::CH_NUL;
                    edte_pkg::CH_T:    kind  = edte_pkg::MAIN_TAB;
                    edte_pkg::CH_X: begin
                        kind = edte_pkg::MAIN_NONE;
                        if (i_last) begin
                            pre_cnt = 2'd2;
                        end else begin
                            nxt_phase = edte_pkg::PH_X;
                        end
                    end
                    default: mbyte = i_byte;
                endcase
            end
            edte_pkg::PH_X: begin
                if (edte_pkg::hex_digit(i_byte)) begin
                    if (i_last) begin
                        // A value that ends after one digit replays it.
                        pre_cnt = 2'd3;
                        third   = i_byte;
                    end else begin
                        nxt_held  = i_byte;
                        nxt_phase = edte_pkg::PH_XH;
                    end
                end else begin
                    pre_cnt   = 2'd2;
                    kind      = pl_kind;
                    nxt_phase = pl_phase;
                end
            end
            default: begin
                nxt_held = 8'h00;
                if (edte_pkg::hex_digit(i_byte)) begin
                    kind  = edte_pkg::MAIN_BYTE;
                    mbyte = {edte_pkg::hex_nibble(i_held), edte_pkg::hex_nibble(i_byte)};
                end else begin
                    pre_cnt   = 2'd3;
                    kind      = pl_kind;
                    nxt_phase = pl_phase;
                end
            end
        endcase
        if (i_last) begin
            nxt_phase = edte_pkg::PH_NORMAL;
            nxt_held  = 8'h00;
        end
    end

    always_comb begin
        o_job.tok = {8'h00, third, edte_pkg::CH_X, edte_pkg::CH_BSL};
        if (kind == edte_pkg::MAIN_TAB) begin
            o_job.tok[pre_cnt] = edte_pkg::CH_SP;
        end else if (kind == edte_pkg::MAIN_BYTE) begin
            o_job.tok[pre_cnt] = mbyte;
        end
        o_job.n_tok = {1'b0, pre_cnt} + {2'b00, (kind != edte_pkg::MAIN_NONE)};
        o_job.rep   = (kind == edte_pkg::MAIN_TAB);
        o_job.last  = i_last;
    end

    assign o_phase = nxt_phase;
    assign o_held  = nxt_held;

endmodule
